@@ src/mt_uniform_draw_generator_top_macros.svh @@
// assertion macros for the uniform draw generator
// used by the top level only, expects clk and rst in scope
`ifndef MT_UNIFORM_DRAW_GENERATOR_TOP_MACROS_SVH
`define MT_UNIFORM_DRAW_GENERATOR_TOP_MACROS_SVH

// same-cycle implication
`define MTUD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MTUD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/mtud_pkg.sv @@
// shared types and constants of the uniform draw generator
// no dependencies
package mtud_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned DIV_W  = 33;
  localparam int unsigned FRAC_W = 53;

  localparam logic [IDX_W-1:0]  MT_N_LAST  = 10'd623;
  localparam logic [IDX_W:0]    MT_M       = 11'd397;
  localparam logic [IDX_W:0]    MT_N       = 11'd624;
  localparam logic [WORD_W-1:0] MT_MATRIX  = 32'h9908_B0DF;
  localparam logic [WORD_W-1:0] MT_UPPER   = 32'h8000_0000;
  localparam logic [WORD_W-1:0] MT_LOWER   = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] INIT_MULT  = 32'd1812433253;
  localparam logic [WORD_W-1:0] SEED_RESET = 32'd5489;
  localparam logic [DIV_W-1:0]  WORD_RANGE = 33'h1_0000_0000;

  // engine status seen by the request sequencer
  typedef struct packed {
    logic busy;
    logic vld;
  } eng_status_t;

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & 32'h9D2C_5680);
    y = y ^ ((y << 15) & 32'hEFC6_0000);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

@@ src/mtud_ram.sv @@
// 624-word state memory, one write and one read port, registered read
// depends on mtud_pkg
module mtud_ram
  import mtud_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [IDX_W-1:0]  wa,
  input  logic [WORD_W-1:0] wd,
  input  logic [IDX_W-1:0]  ra,
  output logic [WORD_W-1:0] rd
);

  logic [WORD_W-1:0] mem [0:623];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule

@@ src/mtud_div.sv @@
// restoring divider, one quotient bit per cycle, returns the remainder
// depends on mtud_pkg
module mtud_div
  import mtud_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] rem
);

  logic             busy;
  logic [5:0]       cnt;
  logic [DIV_W-1:0] dvd;
  logic [DIV_W-1:0] dsr;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic [DIV_W-1:0] rem_next;

  always_comb begin
    trial    = {rem, dvd[DIV_W-1]};
    diff     = trial - {1'b0, dsr};
    rem_next = (trial >= {1'b0, dsr}) ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(DIV_W);
        rem  <= '0;
        dvd  <= dividend;
        dsr  <= divisor;
      end else if (busy) begin
        rem <= rem_next;
        dvd <= {dvd[DIV_W-2:0], 1'b0};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ src/mtud_engine.sv @@
// twister engine: seeding sweep and per-word regeneration over the state memory
// depends on mtud_pkg, mtud_ram
module mtud_engine
  import mtud_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr,
  input  logic [WORD_W-1:0] cfg_data,
  input  logic              req,
  output eng_status_t       status,
  output logic [WORD_W-1:0] word
);

  localparam logic [3:0] E_IDLE  = 4'd0;
  localparam logic [3:0] E_SINIT = 4'd1;
  localparam logic [3:0] E_SMUL  = 4'd2;
  localparam logic [3:0] E_SWR   = 4'd3;
  localparam logic [3:0] E_RA    = 4'd4;
  localparam logic [3:0] E_RB    = 4'd5;
  localparam logic [3:0] E_RC    = 4'd6;
  localparam logic [3:0] E_RD    = 4'd7;
  localparam logic [3:0] E_RW    = 4'd8;
  localparam logic [3:0] E_OUT   = 4'd9;

  logic [3:0]        state;
  logic [WORD_W-1:0] seed;
  logic [WORD_W-1:0] prev;
  logic [WORD_W-1:0] prod;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  k;
  logic [IDX_W-1:0]  k1;
  logic [IDX_W-1:0]  km;
  logic [IDX_W:0]    ksum;
  logic [WORD_W-1:0] wa_a, wa_b, wa_c;
  logic [WORD_W-1:0] y;
  logic [WORD_W-1:0] gen;
  logic [WORD_W-1:0] seed_val;
  logic              we;
  logic [IDX_W-1:0]  wa;
  logic [WORD_W-1:0] wd;
  logic [IDX_W-1:0]  ra;
  logic [WORD_W-1:0] rd;

  always_comb begin
    k1   = (k == MT_N_LAST) ? '0 : k + 10'd1;
    ksum = {1'b0, k} + MT_M;
    km   = (ksum >= MT_N) ? IDX_W'(ksum - MT_N) : ksum[IDX_W-1:0];
    y    = (wa_a & MT_UPPER) | (wa_b & MT_LOWER);
    gen  = wa_c ^ (y >> 1) ^ (y[0] ? MT_MATRIX : '0);
    seed_val = prod + {{(WORD_W-IDX_W){1'b0}}, idx};
  end

  always_comb begin
    we = 1'b0;
    wa = k;
    wd = gen;
    unique case (state)
      E_SINIT: begin
        we = 1'b1;
        wa = '0;
        wd = seed;
      end
      E_SWR: begin
        we = 1'b1;
        wa = idx;
        wd = seed_val;
      end
      E_RW: begin
        we = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_comb begin
    unique case (state)
      E_RB:    ra = k1;
      E_RC:    ra = km;
      default: ra = k;
    endcase
  end

  mtud_ram u_ram (
    .clk (clk),
    .we  (we),
    .wa  (wa),
    .wd  (wd),
    .ra  (ra),
    .rd  (rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_SINIT;
      seed  <= SEED_RESET;
      k     <= '0;
      idx   <= '0;
    end else if (cfg_wr) begin
      state <= E_SINIT;
      seed  <= cfg_data;
    end else begin
      unique case (state)
        E_IDLE: begin
          if (req) begin
            state <= E_RA;
          end
        end
        E_SINIT: begin
          prev  <= seed;
          idx   <= 10'd1;
          state <= E_SMUL;
        end
        E_SMUL: begin
          prod  <= WORD_W'(INIT_MULT * (prev ^ (prev >> 30)));
          state <= E_SWR;
        end
        E_SWR: begin
          prev <= seed_val;
          idx  <= idx + 10'd1;
          if (idx == MT_N_LAST) begin
            k     <= '0;
            state <= E_IDLE;
          end else begin
            state <= E_SMUL;
          end
        end
        E_RA: state <= E_RB;
        E_RB: begin
          wa_a  <= rd;
          state <= E_RC;
        end
        E_RC: begin
          wa_b  <= rd;
          state <= E_RD;
        end
        E_RD: begin
          wa_c  <= rd;
          state <= E_RW;
        end
        E_RW: begin
          word  <= temper(gen);
          k     <= k1;
          state <= E_OUT;
        end
        E_OUT:   state <= E_IDLE;
        default: state <= E_IDLE;
      endcase
    end
  end

  assign status.busy = (state != E_IDLE);
  assign status.vld  = (state == E_OUT);

endmodule

@@ src/mt_uniform_draw_generator_top.sv @@
// top level of the uniform draw generator: request sequencer and output word
// depends on mtud_pkg, mtud_engine, mtud_div and the assertion macro header
//
//   channel  | signals                      | content
//   ---------+------------------------------+------------------------------------------
//   s_       | tvalid tready tdata tuser    | request: low_bound, high_bound; mode in tuser
//   m_       | tvalid tready tdata tuser    | result: fraction_bits, integer_value; error
//   cfg_     | wr data                      | seed_value write, reseeds at once
//
// each engine word passes through a request, three reads, the write and the hand-over
// fraction request: two engine words; integer request: a first pass of the shared remainder unit,
//   a new draw per rejected word and a second pass on the accepted one; inverted or single: no draw
// after reset and after every seed write the engine runs the seeding sweep,
//   during which no request word is taken
// the output register lets the next request enter while a result waits on m_tready
`include "mt_uniform_draw_generator_top_macros.svh"
module mt_uniform_draw_generator_top
  import mtud_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // low_bound [31:0], high_bound [63:32]
  input  logic        s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // fraction_bits [52:0], integer_value [84:53], zero fill
  output logic        m_tuser,   // range_error
  input  logic        cfg_wr,
  input  logic [31:0] cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_LIMW  = 3'd2;
  localparam logic [2:0] ST_DRAWI = 3'd3;
  localparam logic [2:0] ST_MODW  = 3'd4;
  localparam logic [2:0] ST_DRAWA = 3'd5;
  localparam logic [2:0] ST_DRAWB = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

  logic [2:0]        state;
  logic              mode;
  logic [WORD_W-1:0] lo;
  logic [WORD_W-1:0] hi;
  logic [DIV_W-1:0]  range;
  logic [DIV_W-1:0]  limit;
  logic [WORD_W-1:0] w1;
  logic [FRAC_W-1:0] frac;
  logic [WORD_W-1:0] ival;
  logic              err;

  logic [WORD_W-1:0] lo_b, hi_b;
  logic [DIV_W-1:0]  range_calc;
  logic              accept;
  logic              eng_req;
  eng_status_t       eng;
  logic [WORD_W-1:0] eng_word;
  logic              div_start;
  logic [DIV_W-1:0]  div_dividend;
  logic [DIV_W-1:0]  div_divisor;
  logic              div_done;
  logic [DIV_W-1:0]  div_rem;
  logic              word_ok;

  // biased compare turns signed order into unsigned order
  assign lo_b       = lo ^ MT_UPPER;
  assign hi_b       = hi ^ MT_UPPER;
  assign range_calc = {1'b0, hi_b} - {1'b0, lo_b} + 33'd1;
  assign word_ok    = ({1'b0, eng_word} < limit);

  assign s_tready = (state == ST_IDLE) && !eng.busy;
  assign accept   = s_tvalid && s_tready;
  assign eng_req  = (state == ST_DRAWI) || (state == ST_DRAWA) || (state == ST_DRAWB);

  // first pass finds 2^32 mod range, second pass reduces an accepted draw
  always_comb begin
    div_start    = 1'b0;
    div_dividend = WORD_RANGE;
    div_divisor  = range;
    if (state == ST_CHECK && mode && !(lo_b > hi_b) && (lo != hi)) begin
      div_start   = 1'b1;
      div_divisor = range_calc;
    end else if (state == ST_DRAWI && eng.vld && word_ok) begin
      div_start    = 1'b1;
      div_dividend = {1'b0, eng_word};
    end
  end

  mtud_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr   (cfg_wr),
    .cfg_data (cfg_data),
    .req      (eng_req),
    .status   (eng),
    .word     (eng_word)
  );

  mtud_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // output word loads from the finish state, else drains on m_tready
      if (state == ST_FIN && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            mode  <= s_tuser;
            lo    <= s_tdata[31:0];
            hi    <= s_tdata[63:32];
            frac  <= '0;
            ival  <= '0;
            err   <= 1'b0;
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          range <= range_calc;
          if (!mode) begin
            state <= ST_DRAWA;
          end else if (lo_b > hi_b) begin
            err   <= 1'b1;
            state <= ST_FIN;
          end else if (lo == hi) begin
            // single value, no draw
            ival  <= lo;
            state <= ST_FIN;
          end else begin
            state <= ST_LIMW;
          end
        end
        ST_LIMW: begin
          if (div_done) begin
            limit <= WORD_RANGE - div_rem;
            state <= ST_DRAWI;
          end
        end
        ST_DRAWI: begin
          // rejected draws simply request again
          if (eng.vld && word_ok) begin
            state <= ST_MODW;
          end
        end
        ST_MODW: begin
          if (div_done) begin
            ival  <= lo + div_rem[WORD_W-1:0];
            state <= ST_FIN;
          end
        end
        ST_DRAWA: begin
          if (eng.vld) begin
            w1    <= eng_word;
            state <= ST_DRAWB;
          end
        end
        ST_DRAWB: begin
          if (eng.vld) begin
            frac  <= {w1[31:5], eng_word[31:6]};
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {3'b000, ival, frac};
            m_tuser  <= err;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `MTUD_ASSERT_NXT(a_accept_check, accept, state == ST_CHECK, "accepted word did not enter check")
  `MTUD_ASSERT_IMP(a_div_wait, div_done, (state == ST_LIMW) || (state == ST_MODW), "divider done outside wait")
  `MTUD_ASSERT_IMP(a_eng_vld, eng.vld, eng_req, "engine word with no request pending")
  `MTUD_ASSERT_IMP(a_err_clean, m_tvalid && m_tuser, m_tdata[84:0] == 85'd0, "error result carries data")

endmodule
